// ----- src/gate_run_despeckle_defines.svh -----
// Assertion macros shared by the despeckle RTL.
`ifndef GATE_RUN_DESPECKLE_DEFINES_SVH
`define GATE_RUN_DESPECKLE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define GRD_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define GRD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- src/grd_pkg.sv -----
// Package for the gate run despeckle filter: types, constants, helpers.
`timescale 1ns / 1ps
package grd_pkg;

   localparam int MAX_SPECKLE = 31;
   localparam int CNT_W       = $clog2(MAX_SPECKLE + 1);
   localparam int VALUE_W     = 32;
   localparam int SPK_W       = 5;
   localparam int CSR_IDX_W   = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_SPECKLE_LEN   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MISSING_VALUE = 1'b1;

   localparam logic [SPK_W-1:0]   SPECKLE_LEN_RESET   = 5'd2;
   localparam logic [VALUE_W-1:0] MISSING_VALUE_RESET = '0;

   typedef struct packed {
      logic [VALUE_W-1:0] gate_value;
      logic               in_boundary;
      logic               ray_end;
   } req_type;

   typedef struct packed {
      logic [VALUE_W-1:0] out_value;
      logic               out_ray_end;
      logic               out_last;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic shift;
   } cell_ctrl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DRAIN,
      ST_LAST
   } state_type;

   function automatic logic [CNT_W-1:0] eff_len(input logic [SPK_W-1:0] spk);
      logic [CNT_W-1:0] r;
      if (int'(spk) > MAX_SPECKLE) begin
         r = CNT_W'(MAX_SPECKLE);
      end else begin
         r = CNT_W'(spk);
      end
      return r;
   endfunction

endpackage

// ----- src/grd_cell.sv -----
// One storage cell of the run buffer chain: loads a gate or takes its neighbor's value.
`timescale 1ns / 1ps
module grd_cell
   import grd_pkg::*;
(
   input  logic               clock,
   input  cell_ctrl_type      ctrl,
   input  logic [VALUE_W-1:0] push_value,
   input  logic [VALUE_W-1:0] next_value,
   output logic [VALUE_W-1:0] value
);

   logic [VALUE_W-1:0] value_ff;
   logic [VALUE_W-1:0] value_in;

   always_comb begin
      value_in = value_ff;
      if (ctrl.load) begin
         value_in = push_value;
      end else if (ctrl.shift) begin
         value_in = next_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

// ----- src/gate_run_despeckle.sv -----
// Top level of the gate run despeckle filter: control, cell chain, output register.
// A request updates the state register; its results then leave through the output register.
// A held gate yields no result and the block stays ready; a request that yields results
// drains the held run of n gates (n <= 31) from the cell chain, one cell shift per cycle
// unless the result channel stalls, then its own result; new requests stall until it is done.
// Reset (synchronous): speckle_len = 2, missing_value = 0, run empty, no pass-through.
`timescale 1ns / 1ps
`include "gate_run_despeckle_defines.svh"
module gate_run_despeckle
   import grd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [VALUE_W-1:0]   csr_data
);

   state_type          state_ff, state_in;
   logic [SPK_W-1:0]   speckle_len_ff, speckle_len_in;
   logic [VALUE_W-1:0] missing_ff, missing_in;
   logic [CNT_W-1:0]   run_count_ff, run_count_in;
   logic               pass_through_ff, pass_through_in;
   logic [VALUE_W-1:0] cur_value_ff, cur_value_in;
   logic               cur_rend_ff, cur_rend_in;
   logic               blank_ff, blank_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic               accept;
   logic               out_load;
   logic               drain_go;
   logic               last_go;
   logic               gate_ok;
   logic               over_len;
   logic               push;
   logic               release_run;
   logic               rel_blank;
   logic               pass_next;
   logic [VALUE_W-1:0] emit_value;
   logic [VALUE_W-1:0] cell_value [MAX_SPECKLE];

   // configuration
   assign csr_ready = 1'b1;

   always_comb begin
      speckle_len_in = speckle_len_ff;
      missing_in     = missing_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_SPECKLE_LEN:   speckle_len_in = csr_data[SPK_W-1:0];
            CSR_MISSING_VALUE: missing_in     = csr_data;
            default: begin
            end
         endcase
      end
   end

   // request decode
   always_comb begin
      gate_ok     = req_data.in_boundary && (req_data.gate_value != missing_ff);
      over_len    = ({1'b0, run_count_ff} + (CNT_W + 1)'(1)) > {1'b0, eff_len(speckle_len_ff)};
      push        = 1'b0;
      release_run = 1'b0;
      rel_blank   = 1'b0;
      pass_next   = 1'b0;
      emit_value  = req_data.gate_value;
      if (pass_through_ff) begin
         pass_next = gate_ok && !req_data.ray_end;
      end else if (gate_ok) begin
         if (over_len) begin
            release_run = 1'b1;
            pass_next   = !req_data.ray_end;
         end else if (req_data.ray_end) begin
            release_run = 1'b1;
            rel_blank   = 1'b1;
            emit_value  = missing_ff;
         end else begin
            push = 1'b1;
         end
      end else begin
         release_run = 1'b1;
         rel_blank   = req_data.in_boundary;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && release_run && (run_count_ff != '0)) begin
               state_in = ST_DRAIN;
            end else if (accept && !push) begin
               state_in = ST_LAST;
            end
         end
         ST_DRAIN: begin
            if (out_load && (run_count_ff == CNT_W'(1))) begin
               state_in = ST_LAST;
            end
         end
         ST_LAST: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs of the state machine
   always_comb begin
      req_stall = 1'b1;
      drain_go  = 1'b0;
      last_go   = 1'b0;
      case (state_ff)
         ST_IDLE:  req_stall = 1'b0;
         ST_DRAIN: drain_go  = out_load;
         ST_LAST:  last_go   = out_load;
         default: begin
         end
      endcase
   end

   assign accept   = req_valid && !req_stall;
   assign out_load = !rsp_valid_ff || !rsp_stall;

   // run state and current request
   always_comb begin
      run_count_in    = run_count_ff;
      pass_through_in = pass_through_ff;
      cur_value_in    = cur_value_ff;
      cur_rend_in     = cur_rend_ff;
      blank_in        = blank_ff;
      if (accept) begin
         pass_through_in = pass_next;
         cur_value_in    = emit_value;
         cur_rend_in     = req_data.ray_end;
         blank_in        = rel_blank;
         if (push) begin
            run_count_in = run_count_ff + CNT_W'(1);
         end
      end else if (drain_go) begin
         run_count_in = run_count_ff - CNT_W'(1);
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (drain_go) begin
         rsp_valid_in            = 1'b1;
         rsp_data_in.out_value   = blank_ff ? missing_ff : cell_value[0];
         rsp_data_in.out_ray_end = 1'b0;
         rsp_data_in.out_last    = 1'b0;
      end else if (last_go) begin
         rsp_valid_in            = 1'b1;
         rsp_data_in.out_value   = cur_value_ff;
         rsp_data_in.out_ray_end = cur_rend_ff;
         rsp_data_in.out_last    = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         speckle_len_ff  <= SPECKLE_LEN_RESET;
         missing_ff      <= MISSING_VALUE_RESET;
         run_count_ff    <= '0;
         pass_through_ff <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         speckle_len_ff  <= speckle_len_in;
         missing_ff      <= missing_in;
         run_count_ff    <= run_count_in;
         pass_through_ff <= pass_through_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_value_ff <= cur_value_in;
      cur_rend_ff  <= cur_rend_in;
      blank_ff     <= blank_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // run buffer: chain of cells, head is cell 0
   for (genvar k = 0; k < MAX_SPECKLE; k++) begin : g_cell
      cell_ctrl_type      ctrl;
      logic [VALUE_W-1:0] nxt;
      assign ctrl.load  = accept && push && (run_count_ff == CNT_W'(k));
      assign ctrl.shift = drain_go;
      if (k == MAX_SPECKLE - 1) begin : g_tail
         assign nxt = cell_value[k];
      end else begin : g_mid
         assign nxt = cell_value[k + 1];
      end
      grd_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .push_value (req_data.gate_value),
         .next_value (nxt),
         .value      (cell_value[k])
      );
   end

   `GRD_ASSERT_IMPL(a_pass_empty, clock, reset, pass_through_ff && (state_ff == ST_IDLE), run_count_ff == '0)
   `GRD_ASSERT_IMPL(a_drain_nonempty, clock, reset, state_ff == ST_DRAIN, run_count_ff != '0)
   `GRD_ASSERT_NEXT(a_drain_out, clock, reset, drain_go, rsp_valid_ff && !rsp_data_ff.out_last)
   `GRD_ASSERT_NEXT(a_last_out, clock, reset, last_go, rsp_valid_ff && rsp_data_ff.out_last)

endmodule
